@@ sv/sqb_pkg.sv @@
// Shared types, codes and constants for the sprite quad batcher.
`default_nettype none
package sqb_pkg;

  localparam int DEF_MAX_SLOTS   = 32;
  localparam int DEF_MAX_SPRITES = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_CAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_SLOTS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_ID      = 3'd4;

  localparam logic [15:0] RST_SCREEN_WIDTH  = 16'd640;
  localparam logic [15:0] RST_SCREEN_HEIGHT = 16'd480;
  localparam logic [10:0] RST_SPRITE_CAP    = 11'd1024;
  localparam logic [5:0]  RST_TEXTURE_SLOTS = 6'd16;
  localparam logic [31:0] RST_WHITE_ID      = 32'd0;

  localparam logic [31:0] WHITE_COLOR = 32'hFFFF_FFFF;
  localparam logic [1:0]  CORNER_LAST = 2'd3;

  // Q2.14 divider geometry
  localparam int Q_FRAC    = 14;
  localparam int NUM_MAG_W = 18;
  localparam int DEN_W     = 16;
  localparam int QB        = 17;
  localparam int REM_W     = NUM_MAG_W + Q_FRAC + 2;
  localparam logic signed [15:0] Q_MAX = 16'sh7FFF;
  localparam logic signed [15:0] Q_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    MODE_BEGIN  = 2'd0,
    MODE_SPRITE = 2'd1,
    MODE_RECT   = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_FLUSH  = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_BIND   = 2'd3
  } kind_t;

  typedef struct packed {
    logic  load_in;
    logic  prep;
    logic  search_next;
    logic  search_hit;
    logic  append;
    logic  do_flush;
    logic  div_start;
    logic  corner_next;
    logic  sprite_inc;
    logic  emit;
    kind_t emit_kind;
    logic  emit_last;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  cap_full;
    logic  tab_full;
    logic  hit;
    logic  search_end;
    logic  div_done;
    logic  out_free;
    logic  corner_last;
  } sts_t;

endpackage
`default_nettype wire

@@ sv/sqb_div.sv @@
// Serial restoring divider lane: rounded, saturated Q2.14 quotient.
`default_nettype none
module sqb_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic                             neg_in,
  input  wire logic [sqb_pkg::NUM_MAG_W-1:0]    mag_in,
  input  wire logic [sqb_pkg::DEN_W-1:0]        den_in,
  output logic                                  done,
  output logic signed [15:0]                    quot
);

  localparam int RW = sqb_pkg::REM_W;
  localparam int QW = sqb_pkg::QB;
  localparam int CW = $clog2(QW);

  logic [RW-1:0] num_full;
  logic [RW-1:0] rem;
  logic [RW-1:0] dsh;
  logic [QW-1:0] q;
  logic [CW-1:0] cnt;
  logic          big;
  logic          neg;
  logic          busy;

  // scaled magnitude plus half the divisor gives round-to-nearest
  assign num_full = RW'({mag_in, {sqb_pkg::Q_FRAC{1'b0}}}) + RW'(den_in >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num_full;
      dsh <= RW'(den_in) << (QW - 1);
      big <= num_full >= (RW'(den_in) << QW);
      neg <= neg_in;
      q   <= '0;
      cnt <= CW'(QW - 1);
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        q   <= {q[QW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
      cnt <= cnt - CW'(1);
    end
  end

  logic [QW-1:0] q_neg;
  assign q_neg = -q;

  always_comb begin
    if (!neg) begin
      quot = (big || q > 17'd32767) ? sqb_pkg::Q_MAX : $signed(q[15:0]);
    end else begin
      quot = (big || q > 17'd32768) ? sqb_pkg::Q_MIN : $signed(q_neg[15:0]);
    end
  end

  assign done = !busy;

endmodule
`default_nettype wire

@@ sv/sqb_ctrl.sv @@
// Controller state machine sequencing flushes, slot search, binds and corners.
`default_nettype none
module sqb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire sqb_pkg::sts_t sts,
  output sqb_pkg::cmd_t      cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DECIDE = 12'b0000_0000_0010,
    S_ERR    = 12'b0000_0000_0100,
    S_END    = 12'b0000_0000_1000,
    S_CAPF   = 12'b0000_0001_0000,
    S_SRD    = 12'b0000_0010_0000,
    S_SCMP   = 12'b0000_0100_0000,
    S_SLOTF  = 12'b0000_1000_0000,
    S_BIND   = 12'b0001_0000_0000,
    S_DIV    = 12'b0010_0000_0000,
    S_DRUN   = 12'b0100_0000_0000,
    S_VERT   = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;
  logic   open, open_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      open  <= 1'b0;
    end else begin
      state <= state_next;
      open  <= open_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    open_next  = open;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.prep = 1'b1;
        priority if (sts.mode == sqb_pkg::MODE_BEGIN) begin
          open_next  = 1'b1;
          state_next = S_IDLE;
        end else if (!open) begin
          state_next = S_ERR;
        end else if (sts.mode == sqb_pkg::MODE_END) begin
          state_next = S_END;
        end else if (sts.cap_full) begin
          state_next = S_CAPF;
        end else if (sts.mode == sqb_pkg::MODE_SPRITE) begin
          state_next = S_SRD;
        end else begin
          state_next = S_DIV;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = sqb_pkg::KIND_ERROR;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_END: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = sqb_pkg::KIND_FLUSH;
          cmd.emit_last = 1'b1;
          cmd.do_flush  = 1'b1;
          open_next     = 1'b0;
          state_next    = S_IDLE;
        end
      end
      S_CAPF: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = sqb_pkg::KIND_FLUSH;
          cmd.do_flush  = 1'b1;
          state_next    = (sts.mode == sqb_pkg::MODE_SPRITE) ? S_SRD : S_DIV;
        end
      end
      S_SRD: begin
        state_next = S_SCMP;
      end
      S_SCMP: begin
        priority if (sts.hit) begin
          cmd.search_hit = 1'b1;
          state_next     = S_DIV;
        end else if (sts.search_end) begin
          state_next = sts.tab_full ? S_SLOTF : S_BIND;
        end else begin
          cmd.search_next = 1'b1;
          state_next      = S_SRD;
        end
      end
      S_SLOTF: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = sqb_pkg::KIND_FLUSH;
          cmd.do_flush  = 1'b1;
          state_next    = S_BIND;
        end
      end
      S_BIND: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = sqb_pkg::KIND_BIND;
          cmd.append    = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_DRUN;
      end
      S_DRUN: begin
        if (sts.div_done) begin
          state_next = S_VERT;
        end
      end
      S_VERT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = sqb_pkg::KIND_VERTEX;
          if (sts.corner_last) begin
            cmd.emit_last  = 1'b1;
            cmd.sprite_inc = 1'b1;
            state_next     = S_IDLE;
          end else begin
            cmd.corner_next = 1'b1;
            state_next      = S_DIV;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result emitted while output register busy");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> sts.div_done)
    else $error("divider restarted while running");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.emit_last) |=> !in_stall)
    else $error("not ready after final result");

endmodule
`default_nettype wire

@@ sv/sqb_dp.sv @@
// Datapath: configuration, slot table, counters, divider lanes, output register.
`default_nettype none
module sqb_dp #(
  parameter int MAX_SLOTS   = sqb_pkg::DEF_MAX_SLOTS,
  parameter int MAX_SPRITES = sqb_pkg::DEF_MAX_SPRITES
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire sqb_pkg::cmd_t                     cmd,
  output sqb_pkg::sts_t                          sts,
  input  wire logic                              cfg_we,
  input  wire logic [sqb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sqb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [1:0]                        mode,
  input  wire logic [31:0]                       texture_id,
  input  wire logic [31:0]                       tex_size,
  input  wire logic signed [15:0]                src_x,
  input  wire logic signed [15:0]                src_y,
  input  wire logic signed [15:0]                src_w,
  input  wire logic signed [15:0]                src_h,
  input  wire logic signed [15:0]                dst_x,
  input  wire logic signed [15:0]                dst_y,
  input  wire logic signed [15:0]                dst_w,
  input  wire logic signed [15:0]                dst_h,
  input  wire logic [31:0]                       fill_color,
  input  wire logic                              out_stall,
  output logic                                   out_valid,
  output logic [1:0]                             kind,
  output logic [10:0]                            sprite_number,
  output logic [1:0]                             corner,
  output logic signed [15:0]                     pos_x,
  output logic signed [15:0]                     pos_y,
  output logic signed [15:0]                     tex_u,
  output logic signed [15:0]                     tex_v,
  output logic [31:0]                            vertex_color,
  output logic [4:0]                             slot_index,
  output logic [31:0]                            bound_texture_id,
  output logic [5:0]                             flushed_slots,
  output logic                                   last
);

  localparam int IW   = $clog2(MAX_SLOTS);
  localparam int SUW  = $clog2(MAX_SLOTS + 1);
  localparam int SQW  = $clog2(MAX_SPRITES + 1);
  localparam int CAPW = (SQW > 11) ? SQW : 11;
  localparam int NSW  = (SUW > 6) ? SUW : 6;
  localparam int MW   = sqb_pkg::NUM_MAG_W;

  function automatic logic signed [19:0] sx20(input logic signed [15:0] v);
    return {{4{v[15]}}, v};
  endfunction

  function automatic logic [MW-1:0] mag_of(input logic signed [19:0] v);
    logic signed [19:0] a;
    a = v[19] ? -v : v;
    return a[MW-1:0];
  endfunction

  // configuration registers
  logic [15:0] screen_width, screen_height;
  logic [10:0] sprite_capacity;
  logic [5:0]  texture_slots;
  logic [31:0] white_texture_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width     <= sqb_pkg::RST_SCREEN_WIDTH;
      screen_height    <= sqb_pkg::RST_SCREEN_HEIGHT;
      sprite_capacity  <= sqb_pkg::RST_SPRITE_CAP;
      texture_slots    <= sqb_pkg::RST_TEXTURE_SLOTS;
      white_texture_id <= sqb_pkg::RST_WHITE_ID;
    end else if (cfg_we) begin
      case (cfg_index)
        sqb_pkg::REG_SCREEN_WIDTH:  screen_width     <= cfg_data[15:0];
        sqb_pkg::REG_SCREEN_HEIGHT: screen_height    <= cfg_data[15:0];
        sqb_pkg::REG_SPRITE_CAP:    sprite_capacity  <= cfg_data[10:0];
        sqb_pkg::REG_TEXTURE_SLOTS: texture_slots    <= cfg_data[5:0];
        sqb_pkg::REG_WHITE_ID:      white_texture_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched transaction
  sqb_pkg::mode_t     mode_r;
  logic [31:0]        tid_r, tsize_r, fill_r;
  logic signed [15:0] sx_r, sy_r, sw_r, sh_r, dx_r, dy_r, dw_r, dh_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r  <= sqb_pkg::mode_t'(mode);
      tid_r   <= texture_id;
      tsize_r <= tex_size;
      fill_r  <= fill_color;
      sx_r    <= src_x;
      sy_r    <= src_y;
      sw_r    <= src_w;
      sh_r    <= src_h;
      dx_r    <= dst_x;
      dy_r    <= dst_y;
      dw_r    <= dst_w;
      dh_r    <= dst_h;
    end
  end

  // batch state
  logic [SUW-1:0] slots_used;
  logic [SQW-1:0] sprites_queued;
  logic [IW-1:0]  idx, slot;
  logic [1:0]     crn;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used     <= SUW'(1);
      sprites_queued <= '0;
    end else begin
      if (cmd.do_flush) begin
        slots_used     <= SUW'(1);
        sprites_queued <= '0;
      end else begin
        if (cmd.append) slots_used <= slots_used + SUW'(1);
        if (cmd.sprite_inc) sprites_queued <= sprites_queued + SQW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      idx  <= '0;
      slot <= '0;
      crn  <= '0;
    end else begin
      if (cmd.search_next) idx <= idx + IW'(1);
      if (cmd.search_hit) slot <= idx;
      if (cmd.append) slot <= slots_used[IW-1:0];
      if (cmd.corner_next) crn <= crn + 2'd1;
    end
  end

  // slot table
  logic [31:0] slot_table [MAX_SLOTS];
  logic [31:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.append) slot_table[slots_used[IW-1:0]] <= tid_r;
    rd_data <= slot_table[idx];
  end

  // limits, clamped to the hardware sizes
  logic [CAPW-1:0] cap_raw, cap;
  logic [NSW-1:0]  nsl_raw, nsl;
  logic [31:0]     entry;

  always_comb begin
    cap_raw = CAPW'(sprite_capacity);
    if (cap_raw == '0) cap = CAPW'(1);
    else if (cap_raw > CAPW'(MAX_SPRITES)) cap = CAPW'(MAX_SPRITES);
    else cap = cap_raw;
    nsl_raw = NSW'(texture_slots);
    if (nsl_raw < NSW'(2)) nsl = NSW'(2);
    else if (nsl_raw > NSW'(MAX_SLOTS)) nsl = NSW'(MAX_SLOTS);
    else nsl = nsl_raw;
  end

  assign entry = (idx == '0) ? white_texture_id : rd_data;

  // numerators for the current corner
  logic [15:0]        hw, hh, texw, texh;
  logic               right, bottom;
  logic signed [19:0] px, py, tx, ty, xn, yn, un, vn;
  logic signed [15:0] qx, qy, qu, qv;
  logic [3:0]         lane_done;

  always_comb begin
    hw     = (screen_width[15:1] == '0) ? 16'd1 : {1'b0, screen_width[15:1]};
    hh     = (screen_height[15:1] == '0) ? 16'd1 : {1'b0, screen_height[15:1]};
    texw   = (tsize_r[31:16] == '0) ? 16'd1 : tsize_r[31:16];
    texh   = (tsize_r[15:0] == '0) ? 16'd1 : tsize_r[15:0];
    right  = (crn == 2'd1) || (crn == 2'd2);
    bottom = crn[1];
    px = sx20(dx_r) + (right ? sx20(dw_r) : 20'sd0);
    py = sx20(dy_r) + (bottom ? sx20(dh_r) : 20'sd0);
    tx = sx20(sx_r) + (right ? sx20(sw_r) : 20'sd0);
    ty = sx20(sy_r) + (bottom ? sx20(sh_r) : 20'sd0);
    xn = px - $signed({4'b0, hw});
    yn = $signed({4'b0, hh}) - py;
    un = tx;
    vn = $signed({4'b0, texh}) - ty;
  end

  sqb_div u_div_x (.clk, .rst, .start(cmd.div_start), .neg_in(xn[19]), .mag_in(mag_of(xn)),
    .den_in(hw), .done(lane_done[0]), .quot(qx));
  sqb_div u_div_y (.clk, .rst, .start(cmd.div_start), .neg_in(yn[19]), .mag_in(mag_of(yn)),
    .den_in(hh), .done(lane_done[1]), .quot(qy));
  sqb_div u_div_u (.clk, .rst, .start(cmd.div_start), .neg_in(un[19]), .mag_in(mag_of(un)),
    .den_in(texw), .done(lane_done[2]), .quot(qu));
  sqb_div u_div_v (.clk, .rst, .start(cmd.div_start), .neg_in(vn[19]), .mag_in(mag_of(vn)),
    .den_in(texh), .done(lane_done[3]), .quot(qv));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind             <= cmd.emit_kind;
      last             <= cmd.emit_last;
      sprite_number    <= '0;
      corner           <= '0;
      pos_x            <= '0;
      pos_y            <= '0;
      tex_u            <= '0;
      tex_v            <= '0;
      vertex_color     <= '0;
      slot_index       <= '0;
      bound_texture_id <= '0;
      flushed_slots    <= '0;
      unique case (cmd.emit_kind)
        sqb_pkg::KIND_VERTEX: begin
          sprite_number <= 11'(sprites_queued);
          corner        <= crn;
          pos_x         <= qx;
          pos_y         <= qy;
          slot_index    <= 5'(slot);
          if (mode_r == sqb_pkg::MODE_SPRITE) begin
            tex_u        <= qu;
            tex_v        <= qv;
            vertex_color <= sqb_pkg::WHITE_COLOR;
          end else begin
            vertex_color <= fill_r;
          end
        end
        sqb_pkg::KIND_FLUSH: begin
          sprite_number <= 11'(sprites_queued);
          flushed_slots <= 6'(slots_used);
        end
        sqb_pkg::KIND_BIND: begin
          slot_index       <= 5'(slots_used);
          bound_texture_id <= tid_r;
        end
        sqb_pkg::KIND_ERROR: ;
      endcase
    end
  end

  always_comb begin
    sts.mode        = mode_r;
    sts.cap_full    = CAPW'(sprites_queued) >= cap;
    sts.tab_full    = NSW'(slots_used) >= nsl;
    sts.hit         = (entry == tid_r);
    sts.search_end  = (SUW'(idx) + SUW'(1)) >= slots_used;
    sts.div_done    = &lane_done;
    sts.out_free    = !out_valid || !out_stall;
    sts.corner_last = (crn == sqb_pkg::CORNER_LAST);
  end

  a_slots_nonzero: assert property (@(posedge clk) disable iff (rst)
    slots_used != '0)
    else $error("slot count dropped to zero");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    CAPW'(sprites_queued) <= CAPW'(MAX_SPRITES))
    else $error("sprite count beyond capacity");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> (NSW'(slots_used) < nsl))
    else $error("slot appended to a full table");

endmodule
`default_nettype wire

@@ sv/sprite_quad_batcher_top.sv @@
// Top level of the sprite quad batcher: controller plus datapath.
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  mode, texture_id, tex_size, src_*, dst_*, fill_color
//  out       output     out_valid / out_stall kind, sprite_number, corner, pos_*, tex_*, ...
//  cfg       input      cfg_we               cfg_index, cfg_data
//
// A draw is accepted, decoded and, for a sprite, searched in the texture table
// (registered read, one read and one compare per slot searched), then emits four
// corners, each a divider start, 17 serial divider steps and a wait for done,
// then an emit. Begin is only accepted and decoded; end and error also emit
// their result. Flush and bind results each add a state that emits them.
// Reset (rst, synchronous) clears the batch, closes drawing and loads the
// register defaults; the slot table holds no reset value.
// A stalled output holds its result; the block waits and accepts the next
// transaction as soon as the final result sits in the output register.
`default_nettype none
module sprite_quad_batcher_top #(
  parameter int MAX_SLOTS   = sqb_pkg::DEF_MAX_SLOTS,
  parameter int MAX_SPRITES = sqb_pkg::DEF_MAX_SPRITES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [sqb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sqb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     mode,
  input  wire logic [31:0]                    texture_id,
  input  wire logic [31:0]                    tex_size,
  input  wire logic signed [15:0]             src_x,
  input  wire logic signed [15:0]             src_y,
  input  wire logic signed [15:0]             src_w,
  input  wire logic signed [15:0]             src_h,
  input  wire logic signed [15:0]             dst_x,
  input  wire logic signed [15:0]             dst_y,
  input  wire logic signed [15:0]             dst_w,
  input  wire logic signed [15:0]             dst_h,
  input  wire logic [31:0]                    fill_color,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          kind,
  output logic [10:0]                         sprite_number,
  output logic [1:0]                          corner,
  output logic signed [15:0]                  pos_x,
  output logic signed [15:0]                  pos_y,
  output logic signed [15:0]                  tex_u,
  output logic signed [15:0]                  tex_v,
  output logic [31:0]                         vertex_color,
  output logic [4:0]                          slot_index,
  output logic [31:0]                         bound_texture_id,
  output logic [5:0]                          flushed_slots,
  output logic                                last
);

  sqb_pkg::cmd_t cmd;
  sqb_pkg::sts_t sts;

  // sequence each transaction
  sqb_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .sts, .cmd
  );

  // hold registers, search the table, divide, drive results
  sqb_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .MAX_SPRITES(MAX_SPRITES)
  ) u_dp (
    .clk, .rst, .cmd, .sts,
    .cfg_we, .cfg_index, .cfg_data,
    .mode, .texture_id, .tex_size,
    .src_x, .src_y, .src_w, .src_h,
    .dst_x, .dst_y, .dst_w, .dst_h,
    .fill_color, .out_stall, .out_valid,
    .kind, .sprite_number, .corner, .pos_x, .pos_y, .tex_u, .tex_v,
    .vertex_color, .slot_index, .bound_texture_id, .flushed_slots, .last
  );

endmodule
`default_nettype wire
